[src/fst_pkg.sv]
package fst_pkg;

  // token capacity and derived widths
  localparam int MAX_TOKEN = 32;
  localparam int LEN_W     = $clog2(MAX_TOKEN + 1);
  localparam int ADDR_W    = (MAX_TOKEN > 1) ? $clog2(MAX_TOKEN) : 1;
  localparam int CHAR_W    = 8;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NUL  = 8'h00;
  localparam logic [CHAR_W-1:0] CH_NL   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_TAB  = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SP   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DQ   = 8'h22;
  localparam logic [CHAR_W-1:0] CH_SQ   = 8'h27;
  localparam logic [CHAR_W-1:0] CH_LPAR = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAR = 8'h29;
  localparam logic [CHAR_W-1:0] CH_DOT  = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_US   = 8'h53;
  localparam logic [CHAR_W-1:0] CH_BSL  = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_LS   = 8'h73;

  // comment modes
  localparam logic [1:0] COMMENT_NONE  = 2'd0;
  localparam logic [1:0] COMMENT_PAREN = 2'd1;
  localparam logic [1:0] COMMENT_LINE  = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic keep_char;
    logic clear_token;
    logic clear_quote;
    logic set_quote;
    logic set_comment;
    logic clear_comment;
    logic start_emit;
    logic emit_subst;
    logic emit_extra;
    logic issue_token;
    logic issue_extra;
  } fst_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_line_end;
    logic is_sep;
    logic is_rpar;
    logic is_closer;
    logic comment_active;
    logic comment_paren;
    logic quote_active;
    logic len_nonzero;
    logic cls_comment;
    logic cls_starter;
    logic slot_free;
    logic issue_last;
    logic em_extra;
  } fst_status_t;

endpackage

[src/fst_ram.sv]
module fst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/fst_ctrl.sv]
module fst_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fst_pkg::fst_status_t sts,
  output fst_pkg::fst_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EMIT  = 2'd1;
  localparam logic [1:0] S_EXTRA = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // characters are taken only while no token is being issued
  assign in_stall = (state_r != S_IDLE);

  // decide per character and sequence token emission
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          priority if (sts.is_line_end) begin
            cmd.clear_token   = 1'b1;
            cmd.clear_quote   = 1'b1;
            cmd.clear_comment = 1'b1;
            if ((sts.quote_active || sts.len_nonzero) && !sts.cls_comment) begin
              cmd.start_emit = 1'b1;
              cmd.emit_subst = sts.cls_starter;
              cmd.emit_extra = sts.cls_starter && !sts.quote_active;
              state_nxt      = S_EMIT;
            end
          end else if (sts.comment_active) begin
            if (sts.comment_paren && sts.is_rpar) begin
              cmd.clear_comment = 1'b1;
            end
          end else if (sts.quote_active) begin
            if (sts.is_closer) begin
              cmd.start_emit  = 1'b1;
              cmd.clear_token = 1'b1;
              cmd.clear_quote = 1'b1;
              state_nxt       = S_EMIT;
            end else begin
              cmd.keep_char = 1'b1;
            end
          end else if (sts.is_sep) begin
            if (sts.len_nonzero) begin
              cmd.clear_token = 1'b1;
              if (sts.cls_comment) begin
                cmd.set_comment = 1'b1;
              end else begin
                cmd.start_emit = 1'b1;
                cmd.emit_subst = sts.cls_starter;
                cmd.set_quote  = sts.cls_starter;
                state_nxt      = S_EMIT;
              end
            end
          end else begin
            cmd.keep_char = 1'b1;
          end
        end
      end
      S_EMIT: begin
        if (sts.slot_free) begin
          cmd.issue_token = 1'b1;
          if (sts.issue_last) begin
            state_nxt = sts.em_extra ? S_EXTRA : S_IDLE;
          end
        end
      end
      S_EXTRA: begin
        if (sts.slot_free) begin
          cmd.issue_extra = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[src/fst_datapath.sv]
module fst_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          in_char_code,
  input  fst_pkg::fst_cmd_t    cmd,
  output fst_pkg::fst_status_t sts,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_token_char,
  output logic                out_token_empty,
  output logic                out_token_last,
  output logic                out_token_truncated
);

  // token collection state
  logic [fst_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic                       ovf_r, ovf_nxt;
  logic [7:0]                 quote_r, quote_nxt;
  logic [1:0]                 comment_r, comment_nxt;
  logic [7:0]                 first_r, first_nxt;
  logic [7:0]                 second_r, second_nxt;

  // emission job
  logic [fst_pkg::LEN_W-1:0]  em_len_r, em_len_nxt;
  logic                       em_trunc_r, em_trunc_nxt;
  logic                       em_subst_r, em_subst_nxt;
  logic                       em_extra_r, em_extra_nxt;
  logic [fst_pkg::LEN_W-1:0]  idx_r, idx_nxt;

  // fetch stage
  logic rd_valid_r, rd_valid_nxt;
  logic rd_empty_r, rd_empty_nxt;
  logic rd_last_r, rd_last_nxt;
  logic rd_trunc_r, rd_trunc_nxt;
  logic rd_dq_r, rd_dq_nxt;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r, out_char_nxt;
  logic       out_empty_r, out_empty_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_trunc_r, out_trunc_nxt;

  // memory port
  logic                        ram_we;
  logic [fst_pkg::ADDR_W-1:0]  ram_waddr;
  logic                        ram_re;
  logic [fst_pkg::ADDR_W-1:0]  ram_raddr;
  logic [7:0]                  ram_rdata;

  logic cls_comment;
  logic cls_starter;
  logic first_is_pfx;
  logic second_is_q;
  logic has_room;
  logic load_out;
  logic slot_free;
  logic issue_last;

  fst_ram #(
    .WIDTH (8),
    .DEPTH (fst_pkg::MAX_TOKEN)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_char_code),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // classify the collected token from its first two characters
  assign first_is_pfx = (first_r == fst_pkg::CH_DOT) || (first_r == fst_pkg::CH_LS) ||
                        (first_r == fst_pkg::CH_US);
  assign second_is_q  = (second_r == fst_pkg::CH_DQ) || (second_r == fst_pkg::CH_LPAR) ||
                        (second_r == fst_pkg::CH_SQ);
  assign cls_comment  = !ovf_r && (len_r == fst_pkg::LEN_W'(1)) &&
                        ((first_r == fst_pkg::CH_LPAR) || (first_r == fst_pkg::CH_BSL));
  assign cls_starter  = !ovf_r && (len_r == fst_pkg::LEN_W'(2)) && first_is_pfx && second_is_q;
  assign has_room     = (len_r < fst_pkg::LEN_W'(fst_pkg::MAX_TOKEN));

  // output handshake and fetch slot
  assign load_out   = rd_valid_r && (!out_valid_r || !out_stall);
  assign slot_free  = !rd_valid_r || load_out;
  assign issue_last = (em_len_r == '0) || (idx_r == em_len_r - fst_pkg::LEN_W'(1));

  // status to controller
  always_comb begin
    sts.is_line_end    = (in_char_code == fst_pkg::CH_NL) || (in_char_code == fst_pkg::CH_NUL);
    sts.is_sep         = (in_char_code == fst_pkg::CH_SP) || (in_char_code == fst_pkg::CH_TAB);
    sts.is_rpar        = (in_char_code == fst_pkg::CH_RPAR);
    sts.is_closer      = (in_char_code == quote_r);
    sts.comment_active = (comment_r != fst_pkg::COMMENT_NONE);
    sts.comment_paren  = (comment_r == fst_pkg::COMMENT_PAREN);
    sts.quote_active   = (quote_r != fst_pkg::CH_NUL);
    sts.len_nonzero    = (len_r != '0);
    sts.cls_comment    = cls_comment;
    sts.cls_starter    = cls_starter;
    sts.slot_free      = slot_free;
    sts.issue_last     = issue_last;
    sts.em_extra       = em_extra_r;
  end

  // collect characters and track quote and comment mode
  always_comb begin
    len_nxt     = len_r;
    ovf_nxt     = ovf_r;
    quote_nxt   = quote_r;
    comment_nxt = comment_r;
    first_nxt   = first_r;
    second_nxt  = second_r;
    ram_we      = 1'b0;
    ram_waddr   = len_r[fst_pkg::ADDR_W-1:0];
    if (cmd.keep_char) begin
      if (has_room) begin
        ram_we  = 1'b1;
        len_nxt = len_r + fst_pkg::LEN_W'(1);
        if (len_r == '0) begin
          first_nxt = in_char_code;
        end
        if (len_r == fst_pkg::LEN_W'(1)) begin
          second_nxt = in_char_code;
        end
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (cmd.clear_token) begin
      len_nxt = '0;
      ovf_nxt = 1'b0;
    end
    if (cmd.set_quote) begin
      quote_nxt = (second_r == fst_pkg::CH_LPAR) ? fst_pkg::CH_RPAR : second_r;
    end
    if (cmd.clear_quote) begin
      quote_nxt = fst_pkg::CH_NUL;
    end
    if (cmd.set_comment) begin
      comment_nxt = (first_r == fst_pkg::CH_LPAR) ? fst_pkg::COMMENT_PAREN
                                                   : fst_pkg::COMMENT_LINE;
    end
    if (cmd.clear_comment) begin
      comment_nxt = fst_pkg::COMMENT_NONE;
    end
  end

  // latch the emission job and issue one result per cycle into the fetch stage while it has a free slot
  always_comb begin
    em_len_nxt   = em_len_r;
    em_trunc_nxt = em_trunc_r;
    em_subst_nxt = em_subst_r;
    em_extra_nxt = em_extra_r;
    idx_nxt      = idx_r;
    rd_valid_nxt = rd_valid_r;
    rd_empty_nxt = rd_empty_r;
    rd_last_nxt  = rd_last_r;
    rd_trunc_nxt = rd_trunc_r;
    rd_dq_nxt    = rd_dq_r;
    ram_re       = 1'b0;
    ram_raddr    = idx_r[fst_pkg::ADDR_W-1:0];
    if (cmd.start_emit) begin
      em_len_nxt   = len_r;
      em_trunc_nxt = ovf_r;
      em_subst_nxt = cmd.emit_subst;
      em_extra_nxt = cmd.emit_extra;
      idx_nxt      = '0;
    end
    if (load_out) begin
      rd_valid_nxt = 1'b0;
    end
    if (cmd.issue_token) begin
      rd_valid_nxt = 1'b1;
      rd_trunc_nxt = em_trunc_r;
      rd_last_nxt  = issue_last;
      if (em_len_r == '0) begin
        rd_empty_nxt = 1'b1;
        rd_dq_nxt    = 1'b0;
      end else begin
        ram_re       = 1'b1;
        rd_empty_nxt = 1'b0;
        rd_dq_nxt    = em_subst_r && (idx_r == fst_pkg::LEN_W'(1));
        idx_nxt      = idx_r + fst_pkg::LEN_W'(1);
      end
    end
    if (cmd.issue_extra) begin
      rd_valid_nxt = 1'b1;
      rd_empty_nxt = 1'b1;
      rd_last_nxt  = 1'b1;
      rd_trunc_nxt = 1'b0;
      rd_dq_nxt    = 1'b0;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_empty_nxt = out_empty_r;
    out_last_nxt  = out_last_r;
    out_trunc_nxt = out_trunc_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = rd_empty_r ? fst_pkg::CH_NUL : (rd_dq_r ? fst_pkg::CH_DQ : ram_rdata);
      out_empty_nxt = rd_empty_r;
      out_last_nxt  = rd_last_r;
      out_trunc_nxt = rd_trunc_r;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      ovf_r       <= 1'b0;
      quote_r     <= fst_pkg::CH_NUL;
      comment_r   <= fst_pkg::COMMENT_NONE;
      em_len_r    <= '0;
      em_trunc_r  <= 1'b0;
      em_subst_r  <= 1'b0;
      em_extra_r  <= 1'b0;
      idx_r       <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      quote_r     <= quote_nxt;
      comment_r   <= comment_nxt;
      em_len_r    <= em_len_nxt;
      em_trunc_r  <= em_trunc_nxt;
      em_subst_r  <= em_subst_nxt;
      em_extra_r  <= em_extra_nxt;
      idx_r       <= idx_nxt;
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    first_r     <= first_nxt;
    second_r    <= second_nxt;
    rd_empty_r  <= rd_empty_nxt;
    rd_last_r   <= rd_last_nxt;
    rd_trunc_r  <= rd_trunc_nxt;
    rd_dq_r     <= rd_dq_nxt;
    out_char_r  <= out_char_nxt;
    out_empty_r <= out_empty_nxt;
    out_last_r  <= out_last_nxt;
    out_trunc_r <= out_trunc_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_token_char      = out_char_r;
  assign out_token_empty     = out_empty_r;
  assign out_token_last      = out_last_r;
  assign out_token_truncated = out_trunc_r;

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= fst_pkg::LEN_W'(fst_pkg::MAX_TOKEN))
    else $error("token length beyond capacity");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (len_r == fst_pkg::LEN_W'(fst_pkg::MAX_TOKEN)))
    else $error("overflow flagged with room left");

  a_modes_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !((comment_r != fst_pkg::COMMENT_NONE) && (quote_r != fst_pkg::CH_NUL)))
    else $error("comment and quote mode both active");

  a_issue_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.issue_token || cmd.issue_extra) |-> slot_free)
    else $error("result issued into a full fetch stage");

  a_fetch_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_valid_r && out_valid_r && out_stall) |=> rd_valid_r)
    else $error("fetched result lost under stall");
`endif

endmodule

[src/forth_source_tokenizer.sv]
// channel   valid      stall       payload
// input     in_valid   in_stall    in_char_code
// output    out_valid  out_stall   out_token_char, out_token_empty, out_token_last,
//                                  out_token_truncated
//
// A character that emits nothing does not hold the input. One that ends a token holds
// it while each kept character is issued (an empty token gives one empty result), plus
// an empty token after a quote starter at a line end. A result passes the registered
// store read, then the output register. Reset is synchronous, active low, and clears
// token, quote and comment state but not the token store. out_stall backs up through
// the output and fetch registers into the sequencer, which then holds in_stall high.
module forth_source_tokenizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_token_char,
  output logic       out_token_empty,
  output logic       out_token_last,
  output logic       out_token_truncated
);

  fst_pkg::fst_cmd_t    cmd;
  fst_pkg::fst_status_t sts;

  // per-character decisions and emission sequencing
  fst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // token store, mode registers and result path
  fst_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_char_code        (in_char_code),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_token_char      (out_token_char),
    .out_token_empty     (out_token_empty),
    .out_token_last      (out_token_last),
    .out_token_truncated (out_token_truncated)
  );

endmodule

[sim/forth_source_tokenizer_tb.sv]
module forth_source_tokenizer_tb;

  // one result item of an emitted token
  typedef struct packed {
    logic [fst_pkg::CHAR_W-1:0] ch;
    logic                       empty;
    logic                       last;
    logic                       trunc;
  } token_beat_t;

  typedef enum logic [1:0] {KIND_PLAIN, KIND_COMMENT, KIND_STARTER} token_kind_t;

  // tokenizer model and queue of token characters still owed by the block
  class token_scoreboard;
    token_beat_t                owed_q[$];
    logic [fst_pkg::CHAR_W-1:0] store [fst_pkg::MAX_TOKEN];
    int unsigned                length;
    logic [fst_pkg::CHAR_W-1:0] closer;
    logic [1:0]                 comment_mode;
    bit                         overflow;
    int                         errors;

    function new();
      length       = 0;
      closer       = fst_pkg::CH_NUL;
      comment_mode = fst_pkg::COMMENT_NONE;
      overflow     = 1'b0;
      errors       = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void owe(logic [fst_pkg::CHAR_W-1:0] ch, logic empty, logic last, logic trunc);
      token_beat_t b;
      b.ch    = ch;
      b.empty = empty;
      b.last  = last;
      b.trunc = trunc;
      owed_q.push_back(b);
    endfunction

    function void keep(logic [fst_pkg::CHAR_W-1:0] c);
      if (length < fst_pkg::MAX_TOKEN) begin
        store[length] = c;
        length++;
      end else begin
        overflow = 1'b1;
      end
    endfunction

    // comment opener or quote starter check; a starter gets its quote substituted
    function token_kind_t classify();
      if (overflow)
        return KIND_PLAIN;
      if (length == 1 && (store[0] == fst_pkg::CH_LPAR || store[0] == fst_pkg::CH_BSL)) begin
        comment_mode = (store[0] == fst_pkg::CH_LPAR) ? fst_pkg::COMMENT_PAREN
                                                       : fst_pkg::COMMENT_LINE;
        return KIND_COMMENT;
      end
      if (length == 2 &&
          (store[0] == fst_pkg::CH_DOT || store[0] == fst_pkg::CH_LS ||
           store[0] == fst_pkg::CH_US) &&
          (store[1] == fst_pkg::CH_DQ || store[1] == fst_pkg::CH_LPAR ||
           store[1] == fst_pkg::CH_SQ)) begin
        closer   = (store[1] == fst_pkg::CH_LPAR) ? fst_pkg::CH_RPAR : store[1];
        store[1] = fst_pkg::CH_DQ;
        return KIND_STARTER;
      end
      return KIND_PLAIN;
    endfunction

    function void emit_token();
      if (length == 0) begin
        owe(fst_pkg::CH_NUL, 1'b1, 1'b1, overflow);
      end else begin
        for (int i = 0; i < length; i++)
          owe(store[i], 1'b0, (i + 1 == length), overflow);
      end
    endfunction

    // advance the model by one accepted character
    function void note_char(logic [fst_pkg::CHAR_W-1:0] c);
      token_kind_t                kind;
      logic [fst_pkg::CHAR_W-1:0] was_quote;
      if (c == fst_pkg::CH_NL || c == fst_pkg::CH_NUL) begin
        if (closer != fst_pkg::CH_NUL || length != 0) begin
          was_quote = closer;
          kind = classify();
          if (kind != KIND_COMMENT)
            emit_token();
          if (kind == KIND_STARTER && was_quote == fst_pkg::CH_NUL)
            owe(fst_pkg::CH_NUL, 1'b1, 1'b1, 1'b0);
        end
        length       = 0;
        overflow     = 1'b0;
        closer       = fst_pkg::CH_NUL;
        comment_mode = fst_pkg::COMMENT_NONE;
      end else if (comment_mode != fst_pkg::COMMENT_NONE) begin
        if (comment_mode == fst_pkg::COMMENT_PAREN && c == fst_pkg::CH_RPAR)
          comment_mode = fst_pkg::COMMENT_NONE;
      end else if (closer != fst_pkg::CH_NUL) begin
        if (c == closer) begin
          emit_token();
          length   = 0;
          overflow = 1'b0;
          closer   = fst_pkg::CH_NUL;
        end else begin
          keep(c);
        end
      end else if (c == fst_pkg::CH_SP || c == fst_pkg::CH_TAB) begin
        if (length != 0) begin
          kind = classify();
          if (kind != KIND_COMMENT)
            emit_token();
          length   = 0;
          overflow = 1'b0;
        end
      end else begin
        keep(c);
      end
    endfunction

    function void check_result(logic [fst_pkg::CHAR_W-1:0] ch, logic empty, logic last,
                               logic trunc);
      token_beat_t want;
      if (owed_q.size() == 0) begin
        $error("unexpected result: token_char %0h empty %0b last %0b", ch, empty, last);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (ch !== want.ch) begin
        $error("token_char: expected %0h, actual %0h", want.ch, ch);
        errors++;
      end
      if (empty !== want.empty) begin
        $error("token_empty: expected %0b, actual %0b", want.empty, empty);
        errors++;
      end
      if (last !== want.last) begin
        $error("token_last: expected %0b, actual %0b", want.last, last);
        errors++;
      end
      if (trunc !== want.trunc) begin
        $error("token_truncated: expected %0b, actual %0b", want.trunc, trunc);
        errors++;
      end
    endfunction
  endclass

  logic                       clk          = 1'b0;
  logic                       rst_n        = 1'b0;
  logic                       in_valid     = 1'b0;
  logic                       in_stall;
  logic [fst_pkg::CHAR_W-1:0] in_char_code = '0;
  logic                       out_valid;
  logic                       out_stall    = 1'b0;
  logic [fst_pkg::CHAR_W-1:0] out_token_char;
  logic                       out_token_empty;
  logic                       out_token_last;
  logic                       out_token_truncated;

  token_scoreboard            sb;
  bit                         calm = 1'b0;
  logic [fst_pkg::CHAR_W-1:0] phrase_q[$];
  string                      word_chars = "abxyzAZ09+-*/@.sS\"'()\\";

  forth_source_tokenizer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_char_code       (in_char_code),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_token_char     (out_token_char),
    .out_token_empty    (out_token_empty),
    .out_token_last     (out_token_last),
    .out_token_truncated(out_token_truncated)
  );

  always #5 clk = ~clk;

  // receiver stalls at random unless in a calm stretch
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 10);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_token_char, out_token_empty, out_token_last, out_token_truncated);
  end

  // watchdog
  initial begin
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end

  // push one character, with random idle cycles ahead of it
  task automatic send_char(logic [fst_pkg::CHAR_W-1:0] c);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= c;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    sb.note_char(c);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i]);
  endtask

  task automatic send_repeat(logic [fst_pkg::CHAR_W-1:0] c, int n);
    repeat (n) send_char(c);
  endtask

  // hold off until every owed result has arrived
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [fst_pkg::CHAR_W-1:0] printable_except(
      logic [fst_pkg::CHAR_W-1:0] avoid);
    logic [fst_pkg::CHAR_W-1:0] c;
    do
      c = fst_pkg::CHAR_W'($urandom_range(8'h7E, 8'h20));
    while (c == avoid);
    return c;
  endfunction

  function automatic logic [fst_pkg::CHAR_W-1:0] pick_sep();
    return $urandom_range(1) ? fst_pkg::CH_SP : fst_pkg::CH_TAB;
  endfunction

  // build one random phrase; returns its number of characters, or 3 for a comment of either kind
  function automatic int build_phrase();
    int                         pick;
    int                         n;
    int                         counted;
    logic [fst_pkg::CHAR_W-1:0] b;
    logic [fst_pkg::CHAR_W-1:0] closer;
    phrase_q.delete();
    counted = 0;
    pick = $urandom_range(99);
    if (pick < 40) begin
      // plain word, sometimes overlong
      n = ($urandom_range(11) == 0) ? $urandom_range(40, 30) : $urandom_range(6, 1);
      repeat (n) phrase_q.push_back(word_chars[$urandom_range(word_chars.len() - 1)]);
      phrase_q.push_back(pick_sep());
      counted = n + 1;
    end else if (pick < 62) begin
      // quote starter and string body
      case ($urandom_range(2))
        0: phrase_q.push_back(fst_pkg::CH_DOT);
        1: phrase_q.push_back(fst_pkg::CH_LS);
        default: phrase_q.push_back(fst_pkg::CH_US);
      endcase
      case ($urandom_range(2))
        0: b = fst_pkg::CH_DQ;
        1: b = fst_pkg::CH_LPAR;
        default: b = fst_pkg::CH_SQ;
      endcase
      closer = (b == fst_pkg::CH_LPAR) ? fst_pkg::CH_RPAR : b;
      phrase_q.push_back(b);
      phrase_q.push_back(pick_sep());
      n = ($urandom_range(15) == 0) ? $urandom_range(38, 31) : $urandom_range(8);
      repeat (n) phrase_q.push_back(printable_except(closer));
      phrase_q.push_back(($urandom_range(4) != 0) ? closer : fst_pkg::CH_NL);
      counted = n + 4;
    end else if (pick < 72) begin
      // comment of either kind
      if ($urandom_range(1)) begin
        phrase_q.push_back(fst_pkg::CH_LPAR);
        phrase_q.push_back(fst_pkg::CH_SP);
        repeat ($urandom_range(6)) phrase_q.push_back(printable_except(fst_pkg::CH_RPAR));
        phrase_q.push_back(fst_pkg::CH_RPAR);
        phrase_q.push_back(pick_sep());
      end else begin
        phrase_q.push_back(fst_pkg::CH_BSL);
        phrase_q.push_back(fst_pkg::CH_SP);
        repeat ($urandom_range(6)) phrase_q.push_back(printable_except(fst_pkg::CH_NL));
        phrase_q.push_back(fst_pkg::CH_NL);
      end
      counted = 3;
    end else if (pick < 82) begin
      phrase_q.push_back(($urandom_range(3) == 0) ? fst_pkg::CH_NUL : fst_pkg::CH_NL);
      counted = 1;
    end else if (pick < 90) begin
      n = $urandom_range(2, 1);
      repeat (n) phrase_q.push_back(pick_sep());
      counted = n;
    end else begin
      // raw byte noise
      n = $urandom_range(3, 1);
      repeat (n) phrase_q.push_back(fst_pkg::CHAR_W'($urandom_range(255)));
      counted = n;
    end
    return counted;
  endfunction

  initial begin
    int  sent;
    bit  paused;
    sb = new();
    sent = 0;
    paused = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: starters, strings, comments, overlong tokens, odd bytes
    send_text("dup .\n");
    send_text(".\" hi there\" x\ts( a b) S' q'\n");
    send_text(".\" \"\n");
    send_text(".\" \n");
    send_text(".\"\n");
    send_text("s\" (\n");
    send_text("s\" .(\n");
    send_text("( skip \\ ) w \\ rest of line\n");
    send_text("( open comment\nz\t\ty\t(\n");
    send_repeat("a", 32);
    send_char(fst_pkg::CH_SP);
    send_repeat("b", 33);
    send_char(fst_pkg::CH_NL);
    send_text("S( ");
    send_repeat("c", 40);
    send_char(fst_pkg::CH_RPAR);
    send_repeat("d", 35);
    send_char(fst_pkg::CH_NUL);
    send_char(8'hFF);
    send_char(8'h80);
    send_char(8'h01);
    send_char(fst_pkg::CH_NUL);
    send_char(fst_pkg::CH_NUL);
    drain();

    // random phrases, with a calm stretch and one full pause
    while (sent < 60) begin
      calm = (sent < 30);
      if (!paused && sent >= 30) begin
        drain();
        paused = 1'b1;
      end
      sent += build_phrase();
      foreach (phrase_q[i])
        send_char(phrase_q[i]);
    end
    calm = 1'b0;
    send_char(fst_pkg::CH_NL);

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("results still owed at end: %0d", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
